// ===== src/cqot_pkg.sv =====
// Shared widths, types and register codes for the circle/quadrilateral overlap test.
package cqot_pkg;

    localparam int COORD_BITS = 16;
    localparam int CW         = COORD_BITS;
    localparam int DW         = CW + 1;          // coordinate difference
    localparam int PW         = 2 * DW;          // signed product of two differences
    localparam int SW         = PW + 1;          // sum of two products
    localparam int MW         = 2 * CW + 1;      // magnitude of a dot, cross or length
    localparam int RW         = CW - 1;          // radius
    localparam int R2W        = 2 * RW;          // radius squared
    localparam int LO_W       = (MW + 1) / 2;    // low half for split products
    localparam int HI_W       = MW - LO_W;
    localparam int CRSQ_W     = 2 * MW;          // cross squared and r^2 * length
    localparam int NC         = 4;               // corners and edges
    localparam int CFG_IDX_W  = 4;

    localparam logic [CFG_IDX_W-1:0] REG_C0X = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_C0Y = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_C1X = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_C1Y = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_C2X = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_C2Y = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_C3X = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_C3Y = CFG_IDX_W'(7);

    typedef logic signed [CW-1:0] t_coord;
    typedef logic signed [DW-1:0] t_diff;
    typedef logic signed [PW-1:0] t_prod;
    typedef logic signed [SW-1:0] t_sum;
    typedef logic        [MW-1:0] t_mag;
    typedef logic        [RW-1:0] t_radius;
    typedef logic       [R2W-1:0] t_r2;
    typedef logic    [CRSQ_W-1:0] t_wide;

    typedef struct packed {
        t_coord [NC-1:0] x;
        t_coord [NC-1:0] y;
    } t_corners;

    // Per-word hand-over from the geometry stages to the edge distance stages
    typedef struct packed {
        logic            hit_pre;   // corner or inside hit already found
        logic [NC-1:0]   ev;        // edge has its projection strictly inside
        t_mag [NC-1:0]   crm;       // |cross| per edge
        t_mag [NC-1:0]   len;       // squared edge length
        t_r2             r2;
    } t_job;

    function automatic t_diff sx(input t_coord v);
        return {v[CW-1], v};
    endfunction

endpackage

// ===== src/cqot_if.sv =====
// Stream and configuration channel interfaces.
interface cqot_in_if import cqot_pkg::*;;
    logic    valid;
    logic    ready;
    t_coord  centre_x;
    t_coord  centre_y;
    t_radius radius;

    modport source(output valid, centre_x, centre_y, radius, input ready);
    modport sink(input valid, centre_x, centre_y, radius, output ready);
endinterface

interface cqot_out_if;
    logic valid;
    logic ready;
    logic hit;

    modport source(output valid, hit, input ready);
    modport sink(input valid, hit, output ready);
endinterface

interface cqot_cfg_if import cqot_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    t_coord               data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ===== src/cqot_cfg_regs.sv =====
// Corner coordinate register file.
module cqot_cfg_regs import cqot_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cqot_cfg_if.sink    i_cfg,
    output t_corners    o_corners
);

    t_corners r_corners;
    t_corners n_corners;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_corners = r_corners;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_C0X: n_corners.x[0] = i_cfg.data;
                REG_C0Y: n_corners.y[0] = i_cfg.data;
                REG_C1X: n_corners.x[1] = i_cfg.data;
                REG_C1Y: n_corners.y[1] = i_cfg.data;
                REG_C2X: n_corners.x[2] = i_cfg.data;
                REG_C2Y: n_corners.y[2] = i_cfg.data;
                REG_C3X: n_corners.x[3] = i_cfg.data;
                REG_C3Y: n_corners.y[3] = i_cfg.data;
                default: n_corners = r_corners;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corners <= '0;
        end else begin
            r_corners <= n_corners;
        end
    end

    assign o_corners = r_corners;

endmodule

// ===== src/cqot_geom.sv =====
// Stages 1-3: differences, products, corner/inside tests and edge projections.
module cqot_geom import cqot_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cqot_in_if.sink     i_in,
    input  t_corners    i_corners,
    output logic        o_job_valid,
    input  logic        i_job_ready,
    output t_job        o_job
);

    logic w_adv1, w_adv2, w_adv3;
    logic r_s1_vld, r_s2_vld, r_s3_vld;

    // stage 1
    t_diff   r_s1_wx [NC], r_s1_wy [NC], r_s1_dx [NC], r_s1_dy [NC];
    t_diff   n_s1_wx [NC], n_s1_wy [NC], n_s1_dx [NC], n_s1_dy [NC];
    t_radius r_s1_r;

    // stage 2
    t_prod r_s2_sqx [NC], r_s2_sqy [NC], r_s2_ux [NC], r_s2_uy [NC];
    t_prod r_s2_cp [NC], r_s2_cn [NC], r_s2_lx [NC], r_s2_ly [NC];
    t_prod n_s2_sqx [NC], n_s2_sqy [NC], n_s2_ux [NC], n_s2_uy [NC];
    t_prod n_s2_cp [NC], n_s2_cn [NC], n_s2_lx [NC], n_s2_ly [NC];
    t_r2   r_s2_r2;
    t_r2   n_s2_r2;

    // stage 3
    t_sum  w_d2 [NC], w_u [NC], w_cr [NC], w_len [NC], w_cra [NC];
    logic  [NC-1:0] w_chit;
    t_job  n_s3_job;
    t_job  r_s3_job;

    assign w_adv3     = !r_s3_vld || i_job_ready;
    assign w_adv2     = !r_s2_vld || w_adv3;
    assign w_adv1     = !r_s1_vld || w_adv2;
    assign i_in.ready = w_adv1;

    always_comb begin
        for (int k = 0; k < NC; k++) begin
            n_s1_wx[k] = sx(i_in.centre_x) - sx(i_corners.x[k]);
            n_s1_wy[k] = sx(i_in.centre_y) - sx(i_corners.y[k]);
            n_s1_dx[k] = sx(i_corners.x[(k + 1) % NC]) - sx(i_corners.x[k]);
            n_s1_dy[k] = sx(i_corners.y[(k + 1) % NC]) - sx(i_corners.y[k]);
        end
    end

    always_comb begin
        for (int k = 0; k < NC; k++) begin
            n_s2_sqx[k] = r_s1_wx[k] * r_s1_wx[k];
            n_s2_sqy[k] = r_s1_wy[k] * r_s1_wy[k];
            n_s2_ux[k]  = r_s1_dx[k] * r_s1_wx[k];
            n_s2_uy[k]  = r_s1_dy[k] * r_s1_wy[k];
            n_s2_cp[k]  = r_s1_dx[k] * r_s1_wy[k];
            n_s2_cn[k]  = r_s1_dy[k] * r_s1_wx[k];
            n_s2_lx[k]  = r_s1_dx[k] * r_s1_dx[k];
            n_s2_ly[k]  = r_s1_dy[k] * r_s1_dy[k];
        end
        n_s2_r2 = r_s1_r * r_s1_r;
    end

    always_comb begin
        for (int k = 0; k < NC; k++) begin
            w_d2[k]  = r_s2_sqx[k] + r_s2_sqy[k];
            w_u[k]   = r_s2_ux[k] + r_s2_uy[k];
            w_cr[k]  = r_s2_cp[k] - r_s2_cn[k];
            w_len[k] = r_s2_lx[k] + r_s2_ly[k];
            w_cra[k] = w_cr[k][SW-1] ? -w_cr[k] : w_cr[k];
            w_chit[k] = w_d2[k] < $signed(SW'(r_s2_r2));
            n_s3_job.ev[k]  = (w_len[k] != '0) && (w_u[k] > 0) && (w_u[k] < w_len[k]);
            n_s3_job.crm[k] = w_cra[k][MW-1:0];
            n_s3_job.len[k] = w_len[k][MW-1:0];
        end
        // inside: cross and dot both non-negative at corner 0 and at corner 2
        n_s3_job.hit_pre = (|w_chit)
                         || (!w_cr[0][SW-1] && !w_u[0][SW-1]
                             && !w_cr[2][SW-1] && !w_u[2][SW-1]);
        n_s3_job.r2 = r_s2_r2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            if (w_adv1) r_s1_vld <= i_in.valid;
            if (w_adv2) r_s2_vld <= r_s1_vld;
            if (w_adv3) r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r_s1_wx <= n_s1_wx;
            r_s1_wy <= n_s1_wy;
            r_s1_dx <= n_s1_dx;
            r_s1_dy <= n_s1_dy;
            r_s1_r  <= i_in.radius;
        end
        if (w_adv2) begin
            r_s2_sqx <= n_s2_sqx;
            r_s2_sqy <= n_s2_sqy;
            r_s2_ux  <= n_s2_ux;
            r_s2_uy  <= n_s2_uy;
            r_s2_cp  <= n_s2_cp;
            r_s2_cn  <= n_s2_cn;
            r_s2_lx  <= n_s2_lx;
            r_s2_ly  <= n_s2_ly;
            r_s2_r2  <= n_s2_r2;
        end
        if (w_adv3) begin
            r_s3_job <= n_s3_job;
        end
    end

    assign o_job_valid = r_s3_vld;
    assign o_job       = r_s3_job;

endmodule

// ===== src/cqot_edge.sv =====
// Stages 4-6: split squares of cross and r^2 * length, compare, final hit register.
module cqot_edge import cqot_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_job_valid,
    output logic        o_job_ready,
    input  t_job        i_job,
    cqot_out_if.source  o_out
);

    logic w_adv4, w_adv5, w_adv6;
    logic r_s4_vld, r_s5_vld, r_s6_vld;

    // stage 4: partial products
    logic [2*HI_W-1:0]      r_s4_hh [NC], n_s4_hh [NC];
    logic [HI_W+LO_W-1:0]   r_s4_hl [NC], n_s4_hl [NC];
    logic [2*LO_W-1:0]      r_s4_ll [NC], n_s4_ll [NC];
    logic [R2W+HI_W-1:0]    r_s4_rh [NC], n_s4_rh [NC];
    logic [R2W+LO_W-1:0]    r_s4_rl [NC], n_s4_rl [NC];
    logic [NC-1:0]          r_s4_ev;
    logic                   r_s4_hit_pre;

    // stage 5: recombined
    t_wide         r_s5_cr2 [NC], n_s5_cr2 [NC];
    t_wide         r_s5_rlen [NC], n_s5_rlen [NC];
    logic [NC-1:0] r_s5_ev;
    logic          r_s5_hit_pre;

    // stage 6: result word
    logic          n_s6_hit;
    logic          r_s6_hit;
    logic [NC-1:0] w_ehit;
    logic [NC-1:0] w_bad_len;

    assign w_adv6      = !r_s6_vld || o_out.ready;
    assign w_adv5      = !r_s5_vld || w_adv6;
    assign w_adv4      = !r_s4_vld || w_adv5;
    assign o_job_ready = w_adv4;

    always_comb begin
        for (int k = 0; k < NC; k++) begin
            n_s4_hh[k] = i_job.crm[k][MW-1:LO_W] * i_job.crm[k][MW-1:LO_W];
            n_s4_hl[k] = i_job.crm[k][MW-1:LO_W] * i_job.crm[k][LO_W-1:0];
            n_s4_ll[k] = i_job.crm[k][LO_W-1:0]  * i_job.crm[k][LO_W-1:0];
            n_s4_rh[k] = i_job.r2 * i_job.len[k][MW-1:LO_W];
            n_s4_rl[k] = i_job.r2 * i_job.len[k][LO_W-1:0];
            w_bad_len[k] = i_job.ev[k] && (i_job.len[k] == '0);
        end
    end

    // cross cross term appears twice, hence the extra shift
    always_comb begin
        for (int k = 0; k < NC; k++) begin
            n_s5_cr2[k]  = (CRSQ_W'(r_s4_hh[k]) << (2 * LO_W))
                         + (CRSQ_W'(r_s4_hl[k]) << (LO_W + 1))
                         + CRSQ_W'(r_s4_ll[k]);
            n_s5_rlen[k] = (CRSQ_W'(r_s4_rh[k]) << LO_W) + CRSQ_W'(r_s4_rl[k]);
        end
    end

    always_comb begin
        for (int k = 0; k < NC; k++) begin
            w_ehit[k] = r_s5_ev[k] && (r_s5_cr2[k] < r_s5_rlen[k]);
        end
        n_s6_hit = r_s5_hit_pre || (|w_ehit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
            r_s5_vld <= 1'b0;
            r_s6_vld <= 1'b0;
        end else begin
            if (w_adv4) r_s4_vld <= i_job_valid;
            if (w_adv5) r_s5_vld <= r_s4_vld;
            if (w_adv6) r_s6_vld <= r_s5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv4) begin
            r_s4_hh      <= n_s4_hh;
            r_s4_hl      <= n_s4_hl;
            r_s4_ll      <= n_s4_ll;
            r_s4_rh      <= n_s4_rh;
            r_s4_rl      <= n_s4_rl;
            r_s4_ev      <= i_job.ev;
            r_s4_hit_pre <= i_job.hit_pre;
        end
        if (w_adv5) begin
            r_s5_cr2     <= n_s5_cr2;
            r_s5_rlen    <= n_s5_rlen;
            r_s5_ev      <= r_s4_ev;
            r_s5_hit_pre <= r_s4_hit_pre;
        end
        if (w_adv6) begin
            r_s6_hit <= n_s6_hit;
        end
    end

    assign o_out.valid = r_s6_vld;
    assign o_out.hit   = r_s6_hit;

    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_job_valid |-> (w_bad_len == '0))
        else $error("edge flagged for distance test with zero length");

    a_s4_to_s5: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s4_vld && w_adv5) |=> r_s5_vld)
        else $error("word lost between stage 4 and stage 5");

    a_pre_hit_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s5_vld && r_s5_hit_pre && w_adv6) |=> (r_s6_vld && r_s6_hit))
        else $error("corner or inside hit dropped at the result stage");

endmodule

// ===== src/circle_quad_overlap_test_core.sv =====
// Circle versus quadrilateral overlap test, six-stage pipeline.
// An accepted word passes through stages 1 to 6 before its result word is valid.
// Throughput: one word per cycle unless the output stalls; stages advance independently,
// so bubbles close up behind a stalled output and nothing is lost or repeated.
// Reset (i_rst_n low at a clock edge) empties the pipeline and clears all corners to zero.
module circle_quad_overlap_test_core import cqot_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cqot_cfg_if.sink    i_cfg,
    cqot_in_if.sink     i_in,
    cqot_out_if.source  o_out
);

    t_corners w_corners;
    logic     w_job_valid;
    logic     w_job_ready;
    t_job     w_job;

    cqot_cfg_regs u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (i_cfg),
        .o_corners (w_corners)
    );

    cqot_geom u_geom (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_corners   (w_corners),
        .o_job_valid (w_job_valid),
        .i_job_ready (w_job_ready),
        .o_job       (w_job)
    );

    cqot_edge u_edge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .o_job_ready (w_job_ready),
        .i_job       (w_job),
        .o_out       (o_out)
    );

endmodule
